[sv/bvl_pkg.sv]
// Package for the battery voltage to level block: the voltage table,
// per-segment interpolation constants, charge state codes and stage types.
// No dependencies.
`timescale 1ns / 1ps

package bvl_pkg;

   // Voltage table, top point first
   localparam int unsigned POINT_COUNT = 13;
   localparam int unsigned SEG_COUNT   = POINT_COUNT - 1;

   localparam int unsigned POINT_MV [POINT_COUNT] = '{
      4186, 4067, 3989, 3922, 3859, 3811, 3778,
      3751, 3717, 3671, 3646, 3579, 3500
   };
   localparam int unsigned POINT_PCT [POINT_COUNT] = '{
      100, 90, 80, 70, 60, 50, 40, 30, 20, 10, 5, 2, 0
   };

   // Field widths
   localparam int unsigned MV_W    = 16;
   localparam int unsigned FLAGS_W = 8;
   localparam int unsigned LEVEL_W = 7;
   localparam int unsigned STATE_W = 2;

   // Internal widths: segment index, offset in a segment, level step,
   // rounding numerator, reciprocal, quotient
   localparam int unsigned SEG_W   = 4;
   localparam int unsigned OFF_W   = 7;
   localparam int unsigned DP_W    = 4;
   localparam int unsigned NUM_W   = 12;
   localparam int unsigned RECIP_W = 15;
   localparam int unsigned QUOT_W  = 4;

   // Width of the numerator times reciprocal product
   localparam int unsigned PROD_W  = NUM_W + RECIP_W;

   // Reciprocal scale: floor(n * ceil(2^S / d) / 2^S) is exact for n * d < 2^S
   localparam int unsigned RECIP_SHIFT = 20;
   localparam int unsigned RECIP_ONE   = 1 << RECIP_SHIFT;

   localparam logic [MV_W-1:0] MV_FULL  = MV_W'(POINT_MV[0]);
   localparam logic [MV_W-1:0] MV_EMPTY = MV_W'(POINT_MV[POINT_COUNT-1]);
   localparam logic [LEVEL_W-1:0] LEVEL_FULL  = LEVEL_W'(POINT_PCT[0]);
   localparam logic [LEVEL_W-1:0] LEVEL_EMPTY = LEVEL_W'(POINT_PCT[POINT_COUNT-1]);

   // Segment span in mV (segment k runs from point k+1 up to point k)
   localparam int unsigned SEG_DV [SEG_COUNT] = '{
      POINT_MV[0]  - POINT_MV[1],  POINT_MV[1]  - POINT_MV[2],
      POINT_MV[2]  - POINT_MV[3],  POINT_MV[3]  - POINT_MV[4],
      POINT_MV[4]  - POINT_MV[5],  POINT_MV[5]  - POINT_MV[6],
      POINT_MV[6]  - POINT_MV[7],  POINT_MV[7]  - POINT_MV[8],
      POINT_MV[8]  - POINT_MV[9],  POINT_MV[9]  - POINT_MV[10],
      POINT_MV[10] - POINT_MV[11], POINT_MV[11] - POINT_MV[12]
   };

   // Level step over each segment
   localparam int unsigned SEG_DP [SEG_COUNT] = '{
      POINT_PCT[0]  - POINT_PCT[1],  POINT_PCT[1]  - POINT_PCT[2],
      POINT_PCT[2]  - POINT_PCT[3],  POINT_PCT[3]  - POINT_PCT[4],
      POINT_PCT[4]  - POINT_PCT[5],  POINT_PCT[5]  - POINT_PCT[6],
      POINT_PCT[6]  - POINT_PCT[7],  POINT_PCT[7]  - POINT_PCT[8],
      POINT_PCT[8]  - POINT_PCT[9],  POINT_PCT[9]  - POINT_PCT[10],
      POINT_PCT[10] - POINT_PCT[11], POINT_PCT[11] - POINT_PCT[12]
   };

   // ceil(2^S / (2 * dv)) per segment
   localparam int unsigned SEG_RECIP [SEG_COUNT] = '{
      (RECIP_ONE + 2*SEG_DV[0]  - 1) / (2*SEG_DV[0]),
      (RECIP_ONE + 2*SEG_DV[1]  - 1) / (2*SEG_DV[1]),
      (RECIP_ONE + 2*SEG_DV[2]  - 1) / (2*SEG_DV[2]),
      (RECIP_ONE + 2*SEG_DV[3]  - 1) / (2*SEG_DV[3]),
      (RECIP_ONE + 2*SEG_DV[4]  - 1) / (2*SEG_DV[4]),
      (RECIP_ONE + 2*SEG_DV[5]  - 1) / (2*SEG_DV[5]),
      (RECIP_ONE + 2*SEG_DV[6]  - 1) / (2*SEG_DV[6]),
      (RECIP_ONE + 2*SEG_DV[7]  - 1) / (2*SEG_DV[7]),
      (RECIP_ONE + 2*SEG_DV[8]  - 1) / (2*SEG_DV[8]),
      (RECIP_ONE + 2*SEG_DV[9]  - 1) / (2*SEG_DV[9]),
      (RECIP_ONE + 2*SEG_DV[10] - 1) / (2*SEG_DV[10]),
      (RECIP_ONE + 2*SEG_DV[11] - 1) / (2*SEG_DV[11])
   };

   // Flag bits of the report
   localparam int unsigned FLAG_CHARGING = 7;
   localparam int unsigned FLAG_SLOW     = 4;
   localparam logic [1:0]  SUBSTATE_FULL = 2'h1;

   typedef enum logic [STATE_W-1:0] {
      STATE_DISCHARGING = 2'd0,
      STATE_RECHARGING  = 2'd1,
      STATE_FULL        = 2'd2,
      STATE_SLOW        = 2'd3
   } charge_state_type;

   // Level saturation class of a word
   typedef enum logic [1:0] {
      SAT_NONE  = 2'd0,
      SAT_FULL  = 2'd1,
      SAT_EMPTY = 2'd2
   } sat_type;

   // First stage result: segment found and offset within it
   typedef struct packed {
      logic                      valid;
      sat_type                   sat;
      logic [SEG_W-1:0]          seg;
      logic [OFF_W-1:0]          off;
      charge_state_type          state;
   } seg_word_type;

endpackage

[sv/bvl_seg_find.sv]
// First pipeline stage: classifies the voltage against the table, finds the
// bracketing segment and offset, and decodes the charge state.
// Depends on bvl_pkg.
`timescale 1ns / 1ps

module bvl_seg_find (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  logic [bvl_pkg::MV_W-1:0]           voltage_mv,
   input  logic [bvl_pkg::FLAGS_W-1:0]        charge_flags,
   output bvl_pkg::seg_word_type              seg_word
);

   bvl_pkg::seg_word_type seg_ff;
   bvl_pkg::seg_word_type seg_in;

   // Segment search: the lowest-numbered segment whose bottom point is at or
   // below the voltage; compares and offsets run in parallel
   always_comb begin
      seg_in       = seg_ff;
      seg_in.valid = in_valid;
      seg_in.seg   = '0;
      seg_in.off   = '0;
      for (int k = bvl_pkg::SEG_COUNT - 1; k >= 0; k--) begin
         if (voltage_mv >= bvl_pkg::MV_W'(bvl_pkg::POINT_MV[k+1])) begin
            seg_in.seg = bvl_pkg::SEG_W'(k);
            seg_in.off = bvl_pkg::OFF_W'(voltage_mv
                                         - bvl_pkg::MV_W'(bvl_pkg::POINT_MV[k+1]));
         end
      end

      // Saturation at either end of the table
      if (voltage_mv >= bvl_pkg::MV_FULL) begin
         seg_in.sat = bvl_pkg::SAT_FULL;
      end else if (voltage_mv <= bvl_pkg::MV_EMPTY) begin
         seg_in.sat = bvl_pkg::SAT_EMPTY;
      end else begin
         seg_in.sat = bvl_pkg::SAT_NONE;
      end

      // Charge state; slow recharge wins over everything
      if (charge_flags[bvl_pkg::FLAG_SLOW]) begin
         seg_in.state = bvl_pkg::STATE_SLOW;
      end else if (charge_flags[bvl_pkg::FLAG_CHARGING]) begin
         if (charge_flags[1:0] == bvl_pkg::SUBSTATE_FULL) begin
            seg_in.state = bvl_pkg::STATE_FULL;
         end else begin
            seg_in.state = bvl_pkg::STATE_RECHARGING;
         end
      end else begin
         seg_in.state = bvl_pkg::STATE_DISCHARGING;
      end
   end

   // Stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff <= '0;
      end else begin
         seg_ff <= seg_in;
      end
   end

   assign seg_word = seg_ff;

endmodule

[sv/battery_voltage_to_level.sv]
// Top level of the battery voltage to level block: four-stage pipeline
// (segment search, rounding numerator, reciprocal multiply, level add).
// Depends on bvl_pkg and bvl_seg_find.
`timescale 1ns / 1ps

// Takes one battery report word per cycle (busy is always low) and gives one
// result word per report on rsp_strobe for a single cycle; the receiver
// cannot hold results off. Each report passes through four register stages:
// table search, numerator multiply-add, multiply by the segment reciprocal,
// and the final level add. Reports are independent, so any pattern of start
// pulses is handled at full rate.

module battery_voltage_to_level (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [bvl_pkg::MV_W-1:0]            req_voltage_mv,
   input  logic [bvl_pkg::FLAGS_W-1:0]         req_charge_flags,
   output logic                                rsp_strobe,
   output logic [bvl_pkg::LEVEL_W-1:0]         rsp_level_percent,
   output logic [bvl_pkg::STATE_W-1:0]         rsp_charge_state
);

   bvl_pkg::seg_word_type s1;

   // Stage 2 registers
   logic                              s2_valid_ff;
   bvl_pkg::sat_type                  s2_sat_ff;
   logic [bvl_pkg::SEG_W-1:0]         s2_seg_ff;
   logic [bvl_pkg::NUM_W-1:0]         s2_num_ff, s2_num_in;
   bvl_pkg::charge_state_type         s2_state_ff;

   // Stage 3 registers
   logic                              s3_valid_ff;
   bvl_pkg::sat_type                  s3_sat_ff;
   logic [bvl_pkg::SEG_W-1:0]         s3_seg_ff;
   logic [bvl_pkg::QUOT_W-1:0]        s3_quot_ff, s3_quot_in;
   bvl_pkg::charge_state_type         s3_state_ff;
   logic [bvl_pkg::PROD_W-1:0]        s3_prod;

   // Output registers
   logic                              out_valid_ff;
   logic [bvl_pkg::LEVEL_W-1:0]       out_level_ff, out_level_in;
   bvl_pkg::charge_state_type         out_state_ff;

   assign busy = 1'b0;

   bvl_seg_find u_seg_find (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (start & ~busy),
      .voltage_mv   (req_voltage_mv),
      .charge_flags (req_charge_flags),
      .seg_word     (s1)
   );

   // Stage 2: n = 2 * dp * off + dv
   always_comb begin
      s2_num_in = bvl_pkg::NUM_W'(
                     {bvl_pkg::DP_W'(bvl_pkg::SEG_DP[s1.seg]), 1'b0} * s1.off
                   + bvl_pkg::NUM_W'(bvl_pkg::SEG_DV[s1.seg]));
   end

   always_ff @(posedge clock) begin
      s2_sat_ff   <= s1.sat;
      s2_seg_ff   <= s1.seg;
      s2_num_ff   <= s2_num_in;
      s2_state_ff <= s1.state;
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1.valid;
      end
   end

   // Stage 3: n / (2 * dv) by the segment reciprocal, exact for this range
   always_comb begin
      s3_prod    = bvl_pkg::PROD_W'(s2_num_ff)
                 * bvl_pkg::PROD_W'(bvl_pkg::RECIP_W'(bvl_pkg::SEG_RECIP[s2_seg_ff]));
      s3_quot_in = s3_prod[bvl_pkg::RECIP_SHIFT +: bvl_pkg::QUOT_W];
   end

   always_ff @(posedge clock) begin
      s3_sat_ff   <= s2_sat_ff;
      s3_seg_ff   <= s2_seg_ff;
      s3_quot_ff  <= s3_quot_in;
      s3_state_ff <= s2_state_ff;
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // Stage 4: saturated level at either end, else bottom level of the segment plus the rounded step
   always_comb begin
      case (s3_sat_ff)
         bvl_pkg::SAT_FULL:  out_level_in = bvl_pkg::LEVEL_FULL;
         bvl_pkg::SAT_EMPTY: out_level_in = bvl_pkg::LEVEL_EMPTY;
         default: begin
            out_level_in = bvl_pkg::LEVEL_W'(bvl_pkg::POINT_PCT[s3_seg_ff + 1'b1])
                         + bvl_pkg::LEVEL_W'(s3_quot_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      out_level_ff <= out_level_in;
      out_state_ff <= s3_state_ff;
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= s3_valid_ff;
      end
   end

   assign rsp_strobe        = out_valid_ff;
   assign rsp_level_percent = out_level_ff;
   assign rsp_charge_state  = out_state_ff;

endmodule

[sim/tb.sv]
// Testbench for battery_voltage_to_level: drives battery report words and
// checks each level/state result word against an in-bench predictor.
// Depends on bvl_pkg and the battery_voltage_to_level RTL.
`timescale 1ns / 1ps

module tb;

   // Own copy of the discharge curve, top knee first
   localparam int unsigned KNEES = 13;
   localparam int unsigned KNEE_MV [KNEES] = '{
      4186, 4067, 3989, 3922, 3859, 3811, 3778,
      3751, 3717, 3671, 3646, 3579, 3500
   };
   localparam int unsigned KNEE_PCT [KNEES] = '{
      100, 90, 80, 70, 60, 50, 40, 30, 20, 10, 5, 2, 0
   };
   localparam int unsigned BIT_CHARGING = 7;
   localparam int unsigned BIT_SLOW     = 4;
   localparam logic [1:0]  SUB_FULL     = 2'b01;

   localparam int unsigned TAIL_CYCLES  = 8;     // wait before the final check
   localparam int unsigned STALL_LIMIT  = 1000;  // idle gaps are short

   typedef struct packed {
      logic [bvl_pkg::LEVEL_W-1:0] level;
      bvl_pkg::charge_state_type   state;
   } battery_reading_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic [bvl_pkg::MV_W-1:0]     req_voltage_mv = '0;
   logic [bvl_pkg::FLAGS_W-1:0]  req_charge_flags = '0;
   logic                         rsp_strobe;
   logic [bvl_pkg::LEVEL_W-1:0]  rsp_level_percent;
   logic [bvl_pkg::STATE_W-1:0]  rsp_charge_state;

   battery_reading_type pending_readings [$];
   battery_reading_type due_reading;
   int unsigned         send_idle_pct = 0;
   int unsigned         reports_sent = 0;
   int unsigned         readings_checked = 0;
   int unsigned         error_count = 0;
   int unsigned         stall_cycles = 0;

   always #10 clock = ~clock;

   battery_voltage_to_level u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_voltage_mv    (req_voltage_mv),
      .req_charge_flags  (req_charge_flags),
      .rsp_strobe        (rsp_strobe),
      .rsp_level_percent (rsp_level_percent),
      .rsp_charge_state  (rsp_charge_state)
   );

   // Level predictor: saturate outside the curve, else interpolate the
   // highest bracketing segment and round half up
   function automatic logic [bvl_pkg::LEVEL_W-1:0] predict_level(
         input logic [bvl_pkg::MV_W-1:0] mv);
      int unsigned v;
      int unsigned dv;
      int unsigned dp;
      int unsigned k;
      v = mv;
      if (v >= KNEE_MV[0]) return bvl_pkg::LEVEL_W'(KNEE_PCT[0]);
      if (v <= KNEE_MV[KNEES-1]) return bvl_pkg::LEVEL_W'(KNEE_PCT[KNEES-1]);
      for (k = 0; k + 1 < KNEES; k++) begin
         if (v >= KNEE_MV[k+1] && v <= KNEE_MV[k]) begin
            dv = KNEE_MV[k] - KNEE_MV[k+1];
            dp = KNEE_PCT[k] - KNEE_PCT[k+1];
            return bvl_pkg::LEVEL_W'(KNEE_PCT[k+1]
                                     + (2 * dp * (v - KNEE_MV[k+1]) + dv) / (2 * dv));
         end
      end
      return '0;
   endfunction

   // State predictor: slow flag wins, then charging with full substate
   function automatic bvl_pkg::charge_state_type predict_state(
         input logic [bvl_pkg::FLAGS_W-1:0] flags);
      bvl_pkg::charge_state_type st;
      st = bvl_pkg::STATE_DISCHARGING;
      if (flags[BIT_CHARGING])
         st = (flags[1:0] == SUB_FULL) ? bvl_pkg::STATE_FULL : bvl_pkg::STATE_RECHARGING;
      if (flags[BIT_SLOW])
         st = bvl_pkg::STATE_SLOW;
      return st;
   endfunction

   // Drive one report word, wait for it to be taken, then idle cycle by
   // cycle with the set probability
   task automatic send_report(input logic [bvl_pkg::MV_W-1:0] mv,
                              input logic [bvl_pkg::FLAGS_W-1:0] flags);
      battery_reading_type r;
      start            <= 1'b1;
      req_voltage_mv   <= mv;
      req_charge_flags <= flags;
      do @(posedge clock); while (busy !== 1'b0);
      r.level = predict_level(mv);
      r.state = predict_state(flags);
      pending_readings.push_back(r);
      reports_sent++;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Hold off the sender until every due result word has come back
   task automatic pause_until_drained();
      start <= 1'b0;
      do @(posedge clock); while (pending_readings.size() > 0);
   endtask

   // Ends of the range and just either side of the saturation points
   task automatic test_saturation();
      send_report(16'd0,     8'h00);
      send_report(16'hFFFF,  8'h80);
      send_report(16'd3499,  8'h81);
      send_report(16'd3501,  8'h10);
      send_report(16'd4185,  8'h83);
      send_report(16'd4187,  8'hEF);
      pause_until_drained();
   endtask

   // Every knee of the curve lands exactly on its own level
   task automatic test_table_points();
      int unsigned k;
      for (k = 0; k < KNEES; k++)
         send_report(bvl_pkg::MV_W'(KNEE_MV[k]), bvl_pkg::FLAGS_W'(k * 8'h13));
      pause_until_drained();
   endtask

   // 3823 mV sits exactly half way between two levels; 3822 just below
   task automatic test_rounding();
      send_report(16'd3823, 8'h00);
      send_report(16'd3822, 8'h80);
      pause_until_drained();
   endtask

   // Flag combinations: substate without charging, charging not full,
   // slow over full, everything set
   task automatic test_charge_states();
      send_report(16'd3900, 8'h01);
      send_report(16'd3900, 8'h83);
      send_report(16'd3900, 8'h91);
      send_report(16'd3900, 8'hFF);
      pause_until_drained();
   endtask

   // Random reports, mostly on the curve, some near knees, some anywhere
   task automatic test_random_reports(input int unsigned count, input int unsigned idle_pct);
      logic [bvl_pkg::MV_W-1:0]    mv;
      logic [bvl_pkg::FLAGS_W-1:0] flags;
      int unsigned                 sel;
      int unsigned                 i;
      send_idle_pct = idle_pct;
      for (i = 0; i < count; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < 70)
            mv = bvl_pkg::MV_W'($urandom_range(KNEE_MV[KNEES-1], KNEE_MV[0]));
         else if (sel < 85)
            mv = bvl_pkg::MV_W'(KNEE_MV[$urandom_range(0, KNEES-1)]
                                + $urandom_range(0, 2) - 1);
         else if (sel < 93)
            mv = bvl_pkg::MV_W'($urandom_range(0, 16'hFFFF));
         else
            mv = bvl_pkg::MV_W'($urandom_range(3400, 4300));
         flags = bvl_pkg::FLAGS_W'($urandom_range(0, 8'hFF));
         if ($urandom_range(0, 99) < 60)
            flags[BIT_SLOW] = 1'b0;
         send_report(mv, flags);
         if ($urandom_range(0, 99) < 2)
            pause_until_drained();
      end
      pause_until_drained();
   endtask

   // Result checker: each strobed word against the oldest due reading
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe === 1'b1) begin
            if (pending_readings.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result word, level %0d state %0d", $time,
                        rsp_level_percent, rsp_charge_state);
            end else begin
               due_reading = pending_readings.pop_front();
               readings_checked++;
               if (rsp_level_percent !== due_reading.level) begin
                  error_count++;
                  $display("%0t: level mismatch, expected %0d, got %0d", $time,
                           due_reading.level, rsp_level_percent);
               end
               if (rsp_charge_state !== due_reading.state) begin
                  error_count++;
                  $display("%0t: state mismatch, expected %0d, got %0d", $time,
                           due_reading.state, rsp_charge_state);
               end
            end
         end else if (rsp_strobe !== 1'b0) begin
            error_count++;
            $display("%0t: strobe unknown, expected 0 or 1, got %b", $time, rsp_strobe);
         end
      end
   end

   // Watchdog on cycles with no word moving either way
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_strobe === 1'b1)
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, stall_cycles);
         $display("tb: errors");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 22;
      test_saturation();
      test_table_points();
      test_rounding();
      test_charge_states();
      test_random_reports(500, 22);
      test_random_reports(500, 85);
      test_random_reports(500, 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_readings.size() != 0) begin
         error_count++;
         $display("%0t: %0d result words never arrived", $time, pending_readings.size());
      end
      $display("summary: %0d reports sent, %0d results checked, %0d errors", reports_sent,
               readings_checked, error_count);
      $display("summary: saturation, every knee, half-up rounding, all charge states");
      if (error_count == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
